### rtl/core/ftxq_pkg.sv
// Shared types, codes and defaults for the transmit frame queue.
`timescale 1ns / 1ps
package ftxq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned MAX_LEN_DEF     = 256;
  localparam logic [15:0] RETRY_DELAY_RST = 16'd250;
  localparam int unsigned FILL_W          = 9;
  localparam int unsigned ENTRY_W         = 32;
  localparam int unsigned PADDR_W         = 3;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_PURGE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_QUEUED        = 3'd0,
    ST_PARKED        = 3'd1,
    ST_BAD_LEN       = 3'd2,
    ST_FULL_LOSSLESS = 3'd3,
    ST_DROPPED       = 3'd4,
    ST_GET_EMPTY     = 3'd5,
    ST_NO_ACTION     = 3'd6
  } status_e;

  typedef enum logic {
    REG_RETRY_DELAY = 1'b0
  } reg_idx_e;

  typedef struct packed {
    status_e           status;
    logic [15:0]       acc_len;
    logic [15:0]       out_len;
    logic [15:0]       out_handle;
    logic              kick;
    logic              congested;
    logic              busy;
    logic              empty;
    logic [FILL_W-1:0] fill;
  } result_t;

endpackage

### rtl/core/ftxq_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module ftxq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ftxq_cfg.sv
// Configuration register file with its register-bus port.
`timescale 1ns / 1ps
module ftxq_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftxq_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [15:0]                   retry_delay_o
);
  import ftxq_pkg::*;

  logic [15:0] retry_delay_q, retry_delay_d;
  logic        sel_retry;

  assign pready    = 1'b1;
  assign sel_retry = (reg_idx_e'(paddr[2]) == REG_RETRY_DELAY);

  always_comb begin
    retry_delay_d = retry_delay_q;
    if (psel && penable && pwrite && pready && sel_retry) begin
      retry_delay_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_delay_q <= RETRY_DELAY_RST;
    end else begin
      retry_delay_q <= retry_delay_d;
    end
  end

  assign prdata        = sel_retry ? {16'd0, retry_delay_q} : 32'd0;
  assign retry_delay_o = retry_delay_q;

endmodule

### rtl/core/ftxq_ctrl.sv
// Queue control: pointers, congestion, overflow slot, retry timer and result register.
`timescale 1ns / 1ps
module ftxq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = ftxq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_LEN     = ftxq_pkg::MAX_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [15:0]       frame_len_i,
  input  logic [15:0]       frame_handle_i,
  input  logic              is_lossless_i,
  input  logic              link_up_i,
  input  logic [15:0]       retry_delay_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ftxq_pkg::result_t result_o
);
  import ftxq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] LO_C    = CNT_W'(QUEUE_DEPTH / 3);
  localparam logic [CNT_W-1:0] HI_C    = CNT_W'((QUEUE_DEPTH * 2) / 3);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [15:0]      MAXL_C  = 16'(MAX_LEN);

  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               cong_q, cong_d;
  logic               ovf_valid_q, ovf_valid_d;
  logic [ENTRY_W-1:0] ovf_entry_q, ovf_entry_d;
  logic [15:0]        cd_q, cd_d;
  logic               pend_q;
  logic               out_valid_q;
  result_t            out_q, pend_res_q, res_d;
  result_t            pend_out;

  logic               accept, get_ok, full;
  logic               we;
  logic [ENTRY_W-1:0] wdata, rdata;
  status_e            status;
  logic [15:0]        acc_len;
  logic               kick;

  ftxq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_ptr_q),
    .wdata_i (wdata),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  assign in_ready_o = !pend_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == DEPTH_C);

  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    cnt_d       = cnt_q;
    cong_d      = cong_q;
    ovf_valid_d = ovf_valid_q;
    ovf_entry_d = ovf_entry_q;
    cd_d        = cd_q;
    status      = ST_NO_ACTION;
    acc_len     = 16'd0;
    kick        = 1'b0;
    we          = 1'b0;
    wdata       = {frame_len_i, frame_handle_i};
    get_ok      = 1'b0;
    if (accept) begin
      case (cmd_e'(cmd_i))
        CMD_PUT: begin
          if (frame_len_i == 16'd0 || frame_len_i > MAXL_C) begin
            status = ST_BAD_LEN;
          end else if (!full) begin
            we       = 1'b1;
            wr_ptr_d = (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + PTR_W'(1);
            cnt_d    = cnt_q + CNT_W'(1);
            status   = ST_QUEUED;
            acc_len  = frame_len_i;
            kick     = 1'b1;
          end else begin
            cong_d = 1'b1;
            if (is_lossless_i) begin
              status = ST_FULL_LOSSLESS;
            end else if (ovf_valid_q) begin
              status = ST_DROPPED;
            end else begin
              ovf_entry_d = {frame_len_i, frame_handle_i};
              ovf_valid_d = 1'b1;
              cd_d        = retry_delay_i;
              status      = ST_PARKED;
              acc_len     = frame_len_i;
            end
          end
        end
        CMD_GET: begin
          if (cnt_q == '0) begin
            cong_d = 1'b0;
            status = ST_GET_EMPTY;
          end else begin
            get_ok   = 1'b1;
            rd_ptr_d = (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + PTR_W'(1);
            cnt_d    = cnt_q - CNT_W'(1);
            status   = ST_QUEUED;
            if (cong_q && cnt_d <= LO_C) begin
              cong_d = 1'b0;
            end
          end
        end
        CMD_TICK: begin
          if (ovf_valid_q) begin
            if (cd_q > 16'd1) begin
              cd_d = cd_q - 16'd1;
            end else if (!link_up_i) begin
              ovf_valid_d = 1'b0;
              cong_d      = 1'b0;
              cd_d        = 16'd0;
              status      = ST_DROPPED;
            end else if (!full) begin
              we          = 1'b1;
              wdata       = ovf_entry_q;
              wr_ptr_d    = (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + PTR_W'(1);
              cnt_d       = cnt_q + CNT_W'(1);
              ovf_valid_d = 1'b0;
              cd_d        = 16'd0;
              kick        = 1'b1;
              status      = ST_QUEUED;
            end else begin
              cd_d = retry_delay_i;
            end
          end
        end
        CMD_PURGE: begin
          rd_ptr_d    = '0;
          wr_ptr_d    = '0;
          cnt_d       = '0;
          ovf_valid_d = 1'b0;
          cong_d      = 1'b0;
          cd_d        = 16'd0;
        end
        default: begin
          status = ST_NO_ACTION;
        end
      endcase
    end
  end

  always_comb begin
    res_d            = '0;
    res_d.status     = status;
    res_d.acc_len    = acc_len;
    res_d.kick       = kick;
    res_d.congested  = cong_d;
    res_d.busy       = cong_d || (cnt_d >= HI_C);
    res_d.empty      = (cnt_d == '0) && !ovf_valid_d;
    res_d.fill       = FILL_W'(cnt_d);
  end

  always_comb begin
    pend_out            = pend_res_q;
    pend_out.out_len    = rdata[31:16];
    pend_out.out_handle = rdata[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      cnt_q       <= '0;
      cong_q      <= 1'b0;
      ovf_valid_q <= 1'b0;
      ovf_entry_q <= '0;
      cd_q        <= 16'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      cnt_q       <= cnt_d;
      cong_q      <= cong_d;
      ovf_valid_q <= ovf_valid_d;
      ovf_entry_q <= ovf_entry_d;
      cd_q        <= cd_d;
      pend_q      <= accept && get_ok;
      if ((accept && !get_ok) || pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && get_ok) begin
      pend_res_q <= res_d;
    end
    if (accept && !get_ok) begin
      out_q <= res_d;
    end else if (pend_q) begin
      out_q <= pend_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("entry count above queue depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == DEPTH_C) |-> (rd_ptr_q == wr_ptr_q))
    else $error("pointers disagree with entry count");

  a_pend_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o)
    else $error("item accepted while a read is pending");

  a_pend_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> out_valid_q)
    else $error("pending read did not reach the result register");

  a_park_cong: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_valid_q) |-> cong_q)
    else $error("frame parked without congestion");
`endif

endmodule

### rtl/core/frame_tx_queue_with_congestion_unit.sv
// Top level of the transmit frame queue with congestion hysteresis.
`timescale 1ns / 1ps
// The block keeps a queue of transmit frames, each stored as a length and a
// handle, plus one overflow slot for a lossy frame that met a full queue.
// Items enter on the s_axis channel; tuser carries the command and the
// lossless flag. Every item gives exactly one result item on m_axis, with the
// status code in tuser and lengths, handle, flags and fill count in tdata.
// Put, tick and purge items show their result in the cycle after acceptance, and a
// new item can be taken every cycle while the receiver takes results. A get reads the
// frame store memory, whose read is registered; its result waits in a pending register,
// with s_axis_tready low, then moves to the output register. When the receiver stalls,
// the result stays in the output register and the block takes no further item until
// that result is taken. Reset empties the queue, clears congestion and the overflow
// slot, and sets the retry delay to 250 ticks; the frame store itself needs no clearing
// pass. The retry delay register is written over the register port at byte address 0;
// the user must write it only while the block is idle; the block does not enforce this.
module frame_tx_queue_with_congestion_unit #(
  parameter int unsigned QUEUE_DEPTH = ftxq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_LEN     = ftxq_pkg::MAX_LEN_DEF,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_W      = ((52 + CNT_W + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // frame_len, frame_handle, link_up, zero fill
  input  logic [39:0]                  s_axis_tdata,
  // cmd, is_lossless
  input  logic [2:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // accepted_len, out_len, out_handle, kick_drain, congested_flag,
  // busy_flag, empty_flag, fill_count, zero fill
  output logic [OUT_W-1:0]             m_axis_tdata,
  // status
  output logic [2:0]                   m_axis_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ftxq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ftxq_pkg::*;

  logic [15:0] retry_delay;
  result_t     result;

  ftxq_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .retry_delay_o (retry_delay)
  );

  ftxq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_LEN     (MAX_LEN)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .cmd_i          (s_axis_tuser[1:0]),
    .frame_len_i    (s_axis_tdata[15:0]),
    .frame_handle_i (s_axis_tdata[31:16]),
    .is_lossless_i  (s_axis_tuser[2]),
    .link_up_i      (s_axis_tdata[32]),
    .retry_delay_i  (retry_delay),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_o       (result)
  );

  assign m_axis_tuser = result.status;
  assign m_axis_tdata = OUT_W'({result.fill[CNT_W-1:0], result.empty, result.busy,
                                result.congested, result.kick, result.out_handle,
                                result.out_len, result.acc_len});

endmodule
